>>> src/sdcs_pkg.sv
// ----------------------------------------------------------------------------
// sdcs_pkg
// Types, codes and helper functions shared by the SD command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package sdcs_pkg;

    localparam int unsigned SECTOR_BYTES = 512;
    localparam int unsigned SECTOR_SHIFT = $clog2(SECTOR_BYTES);

    typedef enum logic [2:0] {
        OP_START  = 3'd0,
        OP_CMD    = 3'd1,
        OP_READ   = 3'd2,
        OP_WRITE  = 3'd3,
        OP_DATA   = 3'd4,
        OP_DEINIT = 3'd5
    } t_op;

    typedef enum logic [4:0] {
        PH_IDLE, PH_RST0, PH_RST1, PH_IFC, PH_OPC, PH_CID, PH_RCA, PH_CSD,
        PH_SEL, PH_CD, PH_BLEN, PH_RD_CMD, PH_RD_DATA, PH_WR_CMD, PH_WR_DATA,
        PH_WR_POLL, PH_DI_CD, PH_DI_SEL, PH_DI_IDLE
    } t_phase;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } t_ctl_state;

    localparam logic [3:0] ER_NONE  = 4'd0;
    localparam logic [3:0] ER_IFC   = 4'd1;
    localparam logic [3:0] ER_OPC   = 4'd2;
    localparam logic [3:0] ER_CID   = 4'd3;
    localparam logic [3:0] ER_RCA   = 4'd4;
    localparam logic [3:0] ER_CSD   = 4'd5;
    localparam logic [3:0] ER_WRITE = 4'd6;
    localparam logic [3:0] ER_SEL   = 4'd7;
    localparam logic [3:0] ER_CD    = 4'd8;
    localparam logic [3:0] ER_BLEN  = 4'd9;
    localparam logic [3:0] ER_READ  = 4'd10;

    localparam int unsigned FB_INIT   = 0;
    localparam int unsigned FB_XFER   = 1;
    localparam int unsigned FB_HC     = 2;
    localparam int unsigned FB_WP     = 3;
    localparam int unsigned FB_CDOFF  = 4;
    localparam int unsigned FB_DEINIT = 5;

    localparam logic [1:0] RK_NONE  = 2'd0;
    localparam logic [1:0] RK_SHORT = 2'd1;
    localparam logic [1:0] RK_LONG  = 2'd2;

    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_READ  = 2'd1;
    localparam logic [1:0] DIR_WRITE = 2'd2;

    localparam logic [2:0] SEL_INIT = 3'd0;
    localparam logic [2:0] SEL_XFER = 3'd1;

    localparam logic [2:0] CFG_ADAPTER  = 3'd0;
    localparam logic [2:0] CFG_INIT     = 3'd1;
    localparam logic [2:0] CFG_TRANSFER = 3'd2;

    localparam int unsigned DIV_W = 27;

    typedef struct packed {
        logic [2:0]  op;
        logic        resp_timeout;
        logic        resp_crc_fail;
        logic [31:0] resp_word;
        logic [31:0] csd_word;
        logic [31:0] sector;
        logic        data_complete;
    } t_in_item;

    typedef struct packed {
        logic        issue_cmd;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        logic [1:0]  resp_kind;
        logic [1:0]  data_dir;
        logic [16:0] wait_us;
        logic [7:0]  clock_div;
        logic        power_on;
        logic        done_res;
        logic        success;
        logic [3:0]  error_code;
        logic [5:0]  status_flags;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic       div_start;  // begin quotient for the chosen rate
        logic       div_sel;    // 0 init rate, 1 transfer rate
        logic       step;       // evaluate the held item
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic has_result;
    } t_dp_status;

    function automatic logic [1:0] resp_kind_of(input logic [5:0] cmd);
        if (cmd == 6'd0 || cmd == 6'd4 || cmd == 6'd15) return RK_NONE;
        if (cmd == 6'd2 || cmd == 6'd9 || cmd == 6'd10) return RK_LONG;
        return RK_SHORT;
    endfunction

    function automatic logic resp_ok(input logic [5:0] cmd, input logic tmo,
                                     input logic crc);
        if (tmo) return 1'b0;
        if (crc && cmd != 6'd1 && cmd != 6'd5 && cmd != 6'd41) return 1'b0;
        return 1'b1;
    endfunction

endpackage
`default_nettype wire

>>> src/sdcs_stream_if.sv
// ----------------------------------------------------------------------------
// sdcs_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface sdcs_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/sdcs_datapath.sv
// ----------------------------------------------------------------------------
// sdcs_datapath
// Sequencer state registers, serial clock divider and the step logic that
// turns one event into the next command or a completion.
// ----------------------------------------------------------------------------
`default_nettype none
module sdcs_datapath
    import sdcs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [26:0] i_cfg_data,
    input  wire logic       i_load,
    input  wire t_in_item   i_item,
    input  wire t_dp_cmd    i_cmd,
    output t_dp_status      o_status,
    output t_out_item       o_result
);
    logic [26:0] r_adapter_hz;
    logic [18:0] r_init_hz;
    logic [25:0] r_xfer_hz;

    t_in_item    r_item;
    t_phase      r_phase;
    logic [5:0]  r_flags;
    logic [3:0]  r_err;
    logic [15:0] r_rca;
    logic [1:0]  r_ver;
    logic [6:0]  r_att;
    logic        r_app;
    logic [7:0]  r_div;
    logic        r_pwr;

    // restoring divider, one quotient bit a cycle
    logic [26:0] r_rem;
    logic [26:0] r_quo;
    logic [25:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_dbusy;
    logic [7:0]  r_div_res;

    logic [27:0] trial;
    logic [26:0] n_rem_sh;
    logic [7:0]  div_val;

    always_comb begin
        n_rem_sh = {r_rem[25:0], r_quo[26]};
        trial    = {1'b0, n_rem_sh} - {2'b0, r_den};
    end

    always_comb begin
        if (r_den == '0) div_val = 8'd255;
        else if (r_quo > 27'd256) div_val = 8'd255;
        else if (r_quo >= 27'd2) div_val = 8'(r_quo - 27'd2);
        else div_val = 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_cnt   <= '0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
            r_cnt   <= 5'd27;
            r_rem   <= '0;
            r_quo   <= r_adapter_hz;
            r_den   <= i_cmd.div_sel ? r_xfer_hz : {7'd0, r_init_hz};
        end else if (r_dbusy) begin
            if (r_den == '0) begin
                r_dbusy <= 1'b0;
            end else begin
                if (!trial[27]) begin
                    r_rem <= trial[26:0];
                    r_quo <= {r_quo[25:0], 1'b1};
                end else begin
                    r_rem <= n_rem_sh;
                    r_quo <= {r_quo[25:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) r_dbusy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_dbusy) r_div_res <= div_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adapter_hz <= 27'd50000000;
            r_init_hz    <= 19'd400000;
            r_xfer_hz    <= 26'd4000000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ADAPTER:  r_adapter_hz <= i_cfg_data;
                CFG_INIT:     r_init_hz    <= i_cfg_data[18:0];
                CFG_TRANSFER: r_xfer_hz    <= i_cfg_data[25:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_item <= i_item;
    end

    // step logic
    t_phase      n_phase;
    logic [5:0]  n_flags;
    logic [3:0]  n_err;
    logic [15:0] n_rca;
    logic [1:0]  n_ver;
    logic [6:0]  n_att;
    logic        n_app;
    logic [7:0]  n_div;
    logic        n_pwr;
    logic        emit, is_done, ok_v;
    logic [5:0]  e_cmd;
    logic [31:0] e_arg;
    logic [1:0]  e_dir;
    logic [16:0] e_wait;
    logic        need_div;

    // shared check-step parameters for the given phase
    function automatic void chk_params(input t_phase ph, input logic [1:0] ver,
        output logic [5:0] cmd, output logic [31:0] arg, output logic acmd,
        output logic [31:0] expv, output logic [31:0] mask);
        acmd = 1'b1; expv = '0; mask = '0; arg = '0;
        if (ph == PH_OPC) begin
            cmd  = 6'd41;
            arg  = ((ver == 2'd1) ? 32'd0 : 32'h4000_0000) | 32'h0010_0000;
            expv = 32'h8010_0000;
            mask = 32'h8010_0000;
        end else if (ph == PH_BLEN) begin
            cmd  = 6'd16;
            arg  = 32'(SECTOR_BYTES);
            acmd = 1'b0;
            mask = 32'h2000_0000;
        end else begin
            cmd = 6'd42;
            arg = (ph == PH_DI_CD) ? 32'd1 : 32'd0;
        end
    endfunction

    always_comb begin
        logic [5:0]  c_cmd;
        logic [31:0] c_arg, c_exp, c_mask, addr;
        logic        c_acmd;
        logic [1:0]  chk;      // 1 pass, 0 fail, 2 emitted
        logic        chk_run;
        logic        chk_issue;
        logic [16:0] chk_wait;
        logic        begin_chk;
        t_phase      begin_ph;
        logic [6:0]  begin_att;
        logic        do_deinit;
        t_phase      di_from;
        logic [3:0]  st;

        n_phase = r_phase; n_flags = r_flags; n_err = r_err; n_rca = r_rca;
        n_ver = r_ver; n_att = r_att; n_app = r_app; n_div = r_div; n_pwr = r_pwr;
        emit = 1'b0; is_done = 1'b0; ok_v = 1'b0;
        e_cmd = '0; e_arg = '0; e_dir = DIR_NONE; e_wait = '0;
        need_div = 1'b0;
        chk = 2'd0; chk_run = 1'b0; chk_issue = 1'b0; chk_wait = '0;
        begin_chk = 1'b0; begin_ph = PH_IDLE; begin_att = '0;
        do_deinit = 1'b0; di_from = PH_DI_CD; st = '0; addr = '0;
        c_cmd = '0; c_arg = '0; c_exp = '0; c_mask = '0; c_acmd = 1'b0;

        case (r_item.op)
            OP_START: begin
                if (r_phase == PH_IDLE) begin
                    n_pwr = 1'b1; n_flags = '0; n_err = '0; n_rca = '0; n_ver = '0;
                    need_div = 1'b1;
                    n_div = r_div_res;
                    n_phase = PH_RST0;
                    emit = 1'b1; e_cmd = 6'd0; e_wait = 17'd2000;
                end
            end
            OP_CMD: begin
                case (r_phase)
                    PH_RST0: begin
                        n_phase = PH_RST1; emit = 1'b1; e_cmd = 6'd0; e_wait = 17'd100000;
                    end
                    PH_RST1: begin
                        n_phase = PH_IFC; n_att = 7'd2;
                        emit = 1'b1; e_cmd = 6'd8; e_arg = 32'h10A;
                    end
                    PH_IFC: begin
                        if (r_item.resp_timeout || r_item.resp_word[22]) begin
                            n_ver = 2'd1;
                            begin_chk = 1'b1; begin_ph = PH_OPC; begin_att = 7'd19;
                        end else if (resp_ok(6'd8, r_item.resp_timeout,
                                     r_item.resp_crc_fail)
                                     && r_item.resp_word[11:0] == 12'h10A) begin
                            n_ver = 2'd2;
                            begin_chk = 1'b1; begin_ph = PH_OPC; begin_att = 7'd19;
                        end else if (r_att != '0) begin
                            n_att = r_att - 7'd1;
                            emit = 1'b1; e_cmd = 6'd8; e_arg = 32'h10A; e_wait = 17'd1000;
                        end else begin
                            n_err = ER_IFC; is_done = 1'b1;
                        end
                    end
                    PH_OPC, PH_CD, PH_BLEN, PH_DI_CD: chk_run = 1'b1;
                    PH_CID: begin
                        if (!resp_ok(6'd2, r_item.resp_timeout, r_item.resp_crc_fail)) begin
                            n_err = ER_CID; is_done = 1'b1;
                        end else begin
                            n_phase = PH_RCA; emit = 1'b1; e_cmd = 6'd3;
                        end
                    end
                    PH_RCA: begin
                        if (!resp_ok(6'd3, r_item.resp_timeout, r_item.resp_crc_fail)) begin
                            n_err = ER_RCA; is_done = 1'b1;
                        end else begin
                            n_rca = r_item.resp_word[31:16];
                            emit = 1'b1;
                            if (n_rca == '0) begin
                                e_cmd = 6'd3;
                            end else begin
                                n_phase = PH_CSD; e_cmd = 6'd9; e_arg = {n_rca, 16'd0};
                            end
                        end
                    end
                    PH_CSD: begin
                        if (!resp_ok(6'd9, r_item.resp_timeout, r_item.resp_crc_fail)) begin
                            n_err = ER_CSD; is_done = 1'b1;
                        end else if (r_item.csd_word[13:12] != 2'd0) begin
                            n_flags[FB_WP] = 1'b1; n_err = ER_WRITE; is_done = 1'b1;
                        end else begin
                            n_phase = PH_SEL; emit = 1'b1; e_cmd = 6'd7;
                            e_arg = {r_rca, 16'd0};
                        end
                    end
                    PH_SEL: begin
                        if (!resp_ok(6'd7, r_item.resp_timeout, r_item.resp_crc_fail)) begin
                            n_err = ER_SEL; is_done = 1'b1;
                        end else begin
                            need_div = 1'b1;
                            n_div = r_div_res;
                            n_flags[FB_XFER] = 1'b1;
                            begin_chk = 1'b1; begin_ph = PH_CD; begin_att = 7'd2;
                        end
                    end
                    PH_RD_CMD: begin
                        if (!resp_ok(6'd17, r_item.resp_timeout, r_item.resp_crc_fail)) begin
                            n_err = ER_READ; is_done = 1'b1;
                        end else n_phase = PH_RD_DATA;
                    end
                    PH_WR_CMD: begin
                        if (!resp_ok(6'd24, r_item.resp_timeout, r_item.resp_crc_fail)) begin
                            n_err = ER_WRITE; is_done = 1'b1;
                        end else n_phase = PH_WR_DATA;
                    end
                    PH_WR_POLL: begin
                        emit = 1'b1; e_cmd = 6'd13; e_arg = {r_rca, 16'd0};
                        e_wait = 17'd1000;
                        if (!resp_ok(6'd13, r_item.resp_timeout, r_item.resp_crc_fail)) begin
                            if (r_att != '0) n_att = r_att - 7'd1;
                            if (n_att == '0) begin
                                emit = 1'b0; n_err = ER_WRITE; is_done = 1'b1;
                            end
                        end else begin
                            st = r_item.resp_word[12:9];
                            if (st != 4'd6 && st != 4'd7) begin
                                emit = 1'b0; is_done = 1'b1; ok_v = 1'b1;
                            end
                        end
                    end
                    PH_DI_SEL: begin
                        n_flags[FB_XFER] = 1'b0;
                        do_deinit = 1'b1; di_from = PH_DI_IDLE;
                    end
                    PH_DI_IDLE: begin
                        n_pwr = 1'b0; n_rca = '0; is_done = 1'b1; ok_v = 1'b1;
                    end
                    default: ;
                endcase
            end
            OP_READ, OP_WRITE: begin
                if (r_phase == PH_IDLE) begin
                    if (!r_flags[FB_INIT]) begin
                        is_done = 1'b1;
                    end else begin
                        addr = r_flags[FB_HC] ? r_item.sector
                                              : (r_item.sector << SECTOR_SHIFT);
                        emit = 1'b1; e_arg = addr;
                        if (r_item.op == OP_READ) begin
                            n_phase = PH_RD_CMD; e_cmd = 6'd17; e_dir = DIR_READ;
                        end else begin
                            n_phase = PH_WR_CMD; e_cmd = 6'd24; e_dir = DIR_WRITE;
                        end
                    end
                end
            end
            OP_DATA: begin
                if (r_phase == PH_RD_DATA) begin
                    is_done = 1'b1;
                    if (r_item.data_complete) ok_v = 1'b1;
                    else n_err = ER_READ;
                end else if (r_phase == PH_WR_DATA) begin
                    if (!r_item.data_complete) begin
                        n_err = ER_WRITE; is_done = 1'b1;
                    end else begin
                        n_phase = PH_WR_POLL; n_att = 7'd100;
                        emit = 1'b1; e_cmd = 6'd13; e_arg = {r_rca, 16'd0};
                        e_wait = 17'd1000;
                    end
                end
            end
            OP_DEINIT: begin
                if (r_phase == PH_IDLE) begin
                    if (r_flags[FB_DEINIT]) begin
                        is_done = 1'b1; ok_v = 1'b1;
                    end else begin
                        n_flags[FB_DEINIT] = 1'b1;
                        do_deinit = 1'b1; di_from = PH_DI_CD;
                    end
                end
            end
            default: ;
        endcase

        // check-and-retry step for acmd41, acmd42 and cmd16
        if (chk_run) begin
            chk_params(r_phase, r_ver, c_cmd, c_arg, c_acmd, c_exp, c_mask);
            if (c_acmd && !r_app) begin
                if (resp_ok(6'd55, r_item.resp_timeout, r_item.resp_crc_fail)) begin
                    n_app = 1'b1; chk = 2'd2; chk_issue = 1'b1;
                end else if (r_att != '0) begin
                    n_att = r_att - 7'd1; chk = 2'd2; chk_issue = 1'b1;
                    chk_wait = 17'd1000;
                end else chk = 2'd0;
            end else if (resp_ok(c_cmd, r_item.resp_timeout, r_item.resp_crc_fail)
                         && (resp_kind_of(c_cmd) == RK_NONE
                             || (r_item.resp_word & c_mask) == c_exp)) begin
                chk = 2'd1;
            end else if (r_att != '0) begin
                n_att = r_att - 7'd1; n_app = 1'b0; chk = 2'd2; chk_issue = 1'b1;
                chk_wait = (c_cmd == 6'd41) ? 17'd100000 : 17'd1000;
            end else chk = 2'd0;

            if (chk != 2'd2) begin
                case (r_phase)
                    PH_OPC: begin
                        if (chk == 2'd0) begin
                            n_err = ER_OPC; is_done = 1'b1;
                        end else begin
                            if (r_item.resp_word[30]) n_flags[FB_HC] = 1'b1;
                            n_phase = PH_CID; emit = 1'b1; e_cmd = 6'd2;
                        end
                    end
                    PH_CD: begin
                        if (chk == 2'd0) begin
                            n_err = ER_CD; is_done = 1'b1;
                        end else begin
                            n_flags[FB_CDOFF] = 1'b1;
                            begin_chk = 1'b1; begin_ph = PH_BLEN; begin_att = 7'd4;
                        end
                    end
                    PH_BLEN: begin
                        if (chk == 2'd0) begin
                            n_err = ER_BLEN; is_done = 1'b1;
                        end else begin
                            n_flags[FB_INIT] = 1'b1; is_done = 1'b1; ok_v = 1'b1;
                        end
                    end
                    default: begin
                        if (chk == 2'd1) n_flags[FB_CDOFF] = 1'b0;
                        do_deinit = 1'b1; di_from = PH_DI_SEL;
                    end
                endcase
            end
        end

        if (do_deinit) begin
            if (di_from <= PH_DI_CD && n_flags[FB_CDOFF]) begin
                begin_chk = 1'b1; begin_ph = PH_DI_CD; begin_att = 7'd0;
            end else if (di_from <= PH_DI_SEL && n_flags[FB_XFER]) begin
                n_phase = PH_DI_SEL; emit = 1'b1; e_cmd = 6'd7;
            end else begin
                n_phase = PH_DI_IDLE; emit = 1'b1; e_cmd = 6'd0;
            end
        end

        if (begin_chk) begin
            n_phase = begin_ph; n_att = begin_att; n_app = 1'b0;
            chk_issue = 1'b1; chk_wait = '0;
        end

        if (chk_issue) begin
            chk_params(n_phase, n_ver, c_cmd, c_arg, c_acmd, c_exp, c_mask);
            emit = 1'b1; e_wait = chk_wait;
            if (c_acmd && !n_app) begin
                e_cmd = 6'd55; e_arg = {n_rca, 16'd0};
            end else begin
                e_cmd = c_cmd; e_arg = c_arg;
            end
        end

        if (is_done) begin
            emit = 1'b0; n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_flags <= '0; r_err <= '0; r_rca <= '0;
            r_ver <= '0; r_att <= '0; r_app <= 1'b0; r_div <= '0; r_pwr <= 1'b0;
        end else if (i_cmd.step) begin
            r_phase <= n_phase; r_flags <= n_flags; r_err <= n_err; r_rca <= n_rca;
            r_ver <= n_ver; r_att <= n_att; r_app <= n_app; r_div <= n_div;
            r_pwr <= n_pwr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            o_result.issue_cmd    <= emit;
            o_result.cmd_index    <= emit ? e_cmd : 6'd0;
            o_result.cmd_arg      <= emit ? e_arg : 32'd0;
            o_result.resp_kind    <= emit ? resp_kind_of(e_cmd) : RK_NONE;
            o_result.data_dir     <= emit ? e_dir : DIR_NONE;
            o_result.wait_us      <= emit ? e_wait : 17'd0;
            o_result.clock_div    <= n_div;
            o_result.power_on     <= n_pwr;
            o_result.done_res     <= is_done;
            o_result.success      <= is_done & ok_v;
            o_result.error_code   <= n_err;
            o_result.status_flags <= n_flags;
        end
    end

    always_comb begin
        o_status.need_div   = need_div;
        o_status.div_busy   = r_dbusy;
        o_status.has_result = emit | is_done;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> !r_dbusy)
        else $error("step taken while divider busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> r_dbusy || r_den == '0)
        else $error("divider did not start");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && is_done |=> r_phase == PH_IDLE)
        else $error("completion left sequence busy");
endmodule
`default_nettype wire

>>> src/sdcs_ctrl.sv
// ----------------------------------------------------------------------------
// sdcs_ctrl
// Controller: accepts an event, runs the divider when the event needs a new
// clock setting, commits the step and holds the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module sdcs_ctrl
    import sdcs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    input  wire logic       i_sel,
    output t_dp_cmd         o_cmd
);
    t_ctl_state r_state, n_state;
    logic       r_started;
    logic       n_started;
    logic       r_valid, n_valid;

    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        n_valid   = r_valid;
        if (r_valid && i_out_ready) n_valid = 1'b0;
        case (r_state)
            ST_IDLE: if (i_in_valid && !r_valid) begin
                n_state = ST_DIV; n_started = 1'b0;
            end
            ST_DIV: begin
                if (!i_status.need_div) begin
                    n_state = ST_OUT;
                end else if (!r_started) begin
                    n_started = 1'b1;
                end else if (!i_status.div_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                n_state = ST_IDLE;
                n_valid = i_status.has_result;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // after the divider finishes, hold ST_DIV until the divider result has registered
    logic r_settle;
    always_comb begin
        o_in_ready    = (r_state == ST_IDLE) && !r_valid;
        o_out_valid   = r_valid;
        o_cmd.div_start = (r_state == ST_DIV) && i_status.need_div && !r_started;
        o_cmd.div_sel   = i_sel;
        o_cmd.step      = (r_state == ST_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_started <= 1'b0; r_valid <= 1'b0; r_settle <= 1'b0;
        end else begin
            r_state   <= (r_state == ST_DIV && n_state == ST_OUT && !r_settle
                          && i_status.need_div) ? ST_DIV : n_state;
            r_settle  <= (r_state == ST_DIV && n_state == ST_OUT && i_status.need_div)
                          ? 1'b1 : ((r_state == ST_OUT) ? 1'b0 : r_settle);
            r_started <= n_started;
            r_valid   <= n_valid;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> !r_valid)
        else $error("step while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_out_ready |=> r_valid)
        else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("accept while result held");
endmodule
`default_nettype wire

>>> src/sd_card_command_sequencer.sv
// ----------------------------------------------------------------------------
// sd_card_command_sequencer
// SD-card host command sequencer: identification, sector transfer, shutdown.
// ----------------------------------------------------------------------------
// One event beat enters on the in channel (op and response fields); at most
// one result beat leaves on the out channel: either the next command request
// or a completion with error code and status flags. Events that the current
// phase does not expect are absorbed with no result.
// Each accepted event passes through the controller states ST_DIV and ST_OUT,
// and its result is registered in ST_OUT. A start event taken while idle, and
// the successful command completion of the select step, also recompute the
// card clock divider with a bit-serial divider of 27 steps.
// One event is in flight at a time; the next is accepted once the previous
// result has been taken. If the receiver stalls, the result is held and no
// new event is accepted. Reset puts the sequencer idle with flags, error,
// address and divider cleared and the rate registers at their defaults.
// Configuration writes are registered at the clock edge that samples the
// write enable.
// ----------------------------------------------------------------------------
`default_nettype none
module sd_card_command_sequencer
    import sdcs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [26:0] i_cfg_data,
    sdcs_stream_if.sink      in_ch,
    sdcs_stream_if.source    out_ch
);
    t_dp_cmd    cmd;
    t_dp_status status;
    t_out_item  result;
    logic       sel;
    logic       in_ready;
    logic       r_sel;

    assign sel = (in_ch.payload.op == OP_START) ? 1'b0 : 1'b1;

    sdcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_status    (status),
        .i_sel       (r_sel),
        .o_cmd       (cmd)
    );

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ready) r_sel <= sel;
    end

    sdcs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_load      (in_ch.valid && in_ready),
        .i_item      (in_ch.payload),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (result)
    );

    assign in_ch.ready    = in_ready;
    assign out_ch.payload = result;
endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SD command sequencer: event beats are driven
// with random gaps while a transaction-level predictor tracks phase, flags
// and divider and checks every result beat, over several rate settings.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    import sdcs_pkg::*;

    localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
    localparam logic [5:0] CMD_ALL_CID  = 6'd2;
    localparam logic [5:0] CMD_SEND_RCA = 6'd3;
    localparam logic [5:0] CMD_SELECT   = 6'd7;
    localparam logic [5:0] CMD_IF_COND  = 6'd8;
    localparam logic [5:0] CMD_SEND_CSD = 6'd9;
    localparam logic [5:0] CMD_STATUS   = 6'd13;
    localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
    localparam logic [5:0] CMD_READ_BLK = 6'd17;
    localparam logic [5:0] CMD_WRITE_BLK = 6'd24;
    localparam logic [5:0] ACMD_OP_COND = 6'd41;
    localparam logic [5:0] ACMD_CD_PULL = 6'd42;
    localparam logic [5:0] CMD_APP      = 6'd55;
    localparam logic [31:0] OCR_READY   = 32'h8010_0000;
    localparam logic [11:0] IF_PATTERN  = 12'h10A;
    localparam logic [2:0] OP_BAD_A = 3'd6;
    localparam logic [2:0] OP_BAD_B = 3'd7;

    class sdcs_scoreboard;
        logic [26:0] adapter_hz, init_hz, xfer_hz;
        t_phase      phase;
        logic [5:0]  flags;
        logic [3:0]  last_err;
        logic [15:0] rca;
        logic [1:0]  version;
        logic [6:0]  attempts;
        bit          prefix_sent;
        logic [7:0]  divider;
        bit          power;
        t_out_item   pending_q[$];
        int          errors, n_events, n_cmds, n_dones;

        function void reset_state();
            adapter_hz = 27'd50000000;
            init_hz = 27'd400000;
            xfer_hz = 27'd4000000;
            phase = PH_IDLE;
            flags = '0;
            last_err = ER_NONE;
            rca = '0;
            version = '0;
            attempts = '0;
            prefix_sent = 0;
            divider = '0;
            power = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [26:0] val);
            if (idx == CFG_ADAPTER) adapter_hz = val;
            else if (idx == CFG_INIT) init_hz = {8'd0, val[18:0]};
            else if (idx == CFG_TRANSFER) xfer_hz = {1'b0, val[25:0]};
        endfunction

        function logic [1:0] cmd_resp_kind(logic [5:0] cmd);
            if (cmd == CMD_GO_IDLE || cmd == 6'd4 || cmd == 6'd15) return RK_NONE;
            if (cmd == CMD_ALL_CID || cmd == CMD_SEND_CSD || cmd == 6'd10) return RK_LONG;
            return RK_SHORT;
        endfunction

        function bit resp_good(logic [5:0] cmd, logic tmo, logic crc);
            if (tmo) return 0;
            // no crc on these responses
            if (crc && cmd != 6'd1 && cmd != 6'd5 && cmd != ACMD_OP_COND) return 0;
            return 1;
        endfunction

        function logic [7:0] rate_divider(logic [26:0] rate);
            logic [26:0] d;
            if (rate == 0) return 8'd255;
            d = adapter_hz / rate;
            if (d > 256) return 8'd255;
            return (d >= 2) ? 8'(d - 2) : 8'd0;
        endfunction

        function void push_cmd(logic [5:0] cmd, logic [31:0] arg, logic [1:0] dir,
                               logic [16:0] wt);
            t_out_item r;
            r.issue_cmd = 1;
            r.cmd_index = cmd;
            r.cmd_arg = arg;
            r.resp_kind = cmd_resp_kind(cmd);
            r.data_dir = dir;
            r.wait_us = wt;
            r.clock_div = divider;
            r.power_on = power;
            r.done_res = 0;
            r.success = 0;
            r.error_code = last_err;
            r.status_flags = flags;
            pending_q.push_back(r);
        endfunction

        function void push_done(bit ok);
            t_out_item r;
            r = '0;
            r.clock_div = divider;
            r.power_on = power;
            r.done_res = 1;
            r.success = ok;
            r.error_code = last_err;
            r.status_flags = flags;
            pending_q.push_back(r);
            phase = PH_IDLE;
        endfunction

        function void push_fail(logic [3:0] err);
            last_err = err;
            push_done(0);
        endfunction

        function void check_params(output logic [5:0] cmd, output logic [31:0] arg,
                                   output bit acmd, output logic [31:0] want,
                                   output logic [31:0] mask);
            acmd = 1;
            want = '0;
            mask = '0;
            if (phase == PH_OPC) begin
                cmd = ACMD_OP_COND;
                arg = ((version == 1) ? 32'd0 : 32'h4000_0000) | 32'h0010_0000;
                want = OCR_READY;
                mask = OCR_READY;
            end else if (phase == PH_BLEN) begin
                cmd = CMD_BLOCKLEN;
                arg = SECTOR_BYTES;
                acmd = 0;
                mask = 32'h2000_0000;
            end else begin
                cmd = ACMD_CD_PULL;
                arg = (phase == PH_DI_CD) ? 32'd1 : 32'd0;
            end
        endfunction

        function void check_issue(logic [16:0] wt);
            logic [5:0] cmd;
            logic [31:0] arg, want, mask;
            bit acmd;
            check_params(cmd, arg, acmd, want, mask);
            if (acmd && !prefix_sent) push_cmd(CMD_APP, {rca, 16'd0}, DIR_NONE, wt);
            else push_cmd(cmd, arg, DIR_NONE, wt);
        endfunction

        function void check_begin(t_phase ph, int tries);
            phase = ph;
            attempts = 7'(tries - 1);
            prefix_sent = 0;
            check_issue(0);
        endfunction

        // 1 passed, 0 failed with nothing queued, 2 next command queued
        function int check_step(logic tmo, logic crc, logic [31:0] resp);
            logic [5:0] cmd;
            logic [31:0] arg, want, mask;
            bit acmd;
            check_params(cmd, arg, acmd, want, mask);
            if (acmd && !prefix_sent) begin
                if (resp_good(CMD_APP, tmo, crc)) begin
                    prefix_sent = 1;
                    check_issue(0);
                    return 2;
                end
                if (attempts != 0) begin
                    attempts--;
                    check_issue(1000);
                    return 2;
                end
                return 0;
            end
            if (resp_good(cmd, tmo, crc) &&
                (cmd_resp_kind(cmd) == RK_NONE || (resp & mask) == want)) return 1;
            if (attempts != 0) begin
                attempts--;
                prefix_sent = 0;
                check_issue((cmd == ACMD_OP_COND) ? 17'd100000 : 17'd1000);
                return 2;
            end
            return 0;
        endfunction

        function void shutdown_next(t_phase from);
            if (from <= PH_DI_CD && flags[FB_CDOFF]) begin
                check_begin(PH_DI_CD, 1);
                return;
            end
            if (from <= PH_DI_SEL && flags[FB_XFER]) begin
                phase = PH_DI_SEL;
                push_cmd(CMD_SELECT, 0, DIR_NONE, 0);
                return;
            end
            phase = PH_DI_IDLE;
            push_cmd(CMD_GO_IDLE, 0, DIR_NONE, 0);
        endfunction

        function void command_done(logic tmo, logic crc, logic [31:0] resp,
                                   logic [31:0] csd);
            int r;
            logic [3:0] st;
            case (phase)
                PH_RST0: begin
                    phase = PH_RST1;
                    push_cmd(CMD_GO_IDLE, 0, DIR_NONE, 17'd100000);
                end
                PH_RST1: begin
                    phase = PH_IFC;
                    attempts = 2;
                    push_cmd(CMD_IF_COND, IF_PATTERN, DIR_NONE, 0);
                end
                PH_IFC: begin
                    if (tmo || resp[22]) begin
                        version = 1;
                        check_begin(PH_OPC, 20);
                    end else if (resp_good(CMD_IF_COND, tmo, crc) &&
                                 resp[11:0] == IF_PATTERN) begin
                        version = 2;
                        check_begin(PH_OPC, 20);
                    end else if (attempts != 0) begin
                        attempts--;
                        push_cmd(CMD_IF_COND, IF_PATTERN, DIR_NONE, 1000);
                    end else push_fail(ER_IFC);
                end
                PH_OPC: begin
                    r = check_step(tmo, crc, resp);
                    if (r == 0) push_fail(ER_OPC);
                    else if (r == 1) begin
                        if (resp[30]) flags[FB_HC] = 1;
                        phase = PH_CID;
                        push_cmd(CMD_ALL_CID, 0, DIR_NONE, 0);
                    end
                end
                PH_CID: begin
                    if (!resp_good(CMD_ALL_CID, tmo, crc)) push_fail(ER_CID);
                    else begin
                        phase = PH_RCA;
                        push_cmd(CMD_SEND_RCA, 0, DIR_NONE, 0);
                    end
                end
                PH_RCA: begin
                    if (!resp_good(CMD_SEND_RCA, tmo, crc)) push_fail(ER_RCA);
                    else begin
                        rca = resp[31:16];
                        if (rca == 0) push_cmd(CMD_SEND_RCA, 0, DIR_NONE, 0);
                        else begin
                            phase = PH_CSD;
                            push_cmd(CMD_SEND_CSD, {rca, 16'd0}, DIR_NONE, 0);
                        end
                    end
                end
                PH_CSD: begin
                    if (!resp_good(CMD_SEND_CSD, tmo, crc)) push_fail(ER_CSD);
                    else if (csd[13:12] != 0) begin
                        flags[FB_WP] = 1;
                        push_fail(ER_WRITE);
                    end else begin
                        phase = PH_SEL;
                        push_cmd(CMD_SELECT, {rca, 16'd0}, DIR_NONE, 0);
                    end
                end
                PH_SEL: begin
                    if (!resp_good(CMD_SELECT, tmo, crc)) push_fail(ER_SEL);
                    else begin
                        divider = rate_divider(xfer_hz);
                        flags[FB_XFER] = 1;
                        check_begin(PH_CD, 3);
                    end
                end
                PH_CD: begin
                    r = check_step(tmo, crc, resp);
                    if (r == 0) push_fail(ER_CD);
                    else if (r == 1) begin
                        flags[FB_CDOFF] = 1;
                        check_begin(PH_BLEN, 5);
                    end
                end
                PH_BLEN: begin
                    r = check_step(tmo, crc, resp);
                    if (r == 0) push_fail(ER_BLEN);
                    else if (r == 1) begin
                        flags[FB_INIT] = 1;
                        push_done(1);
                    end
                end
                PH_RD_CMD: begin
                    if (!resp_good(CMD_READ_BLK, tmo, crc)) push_fail(ER_READ);
                    else phase = PH_RD_DATA;
                end
                PH_WR_CMD: begin
                    if (!resp_good(CMD_WRITE_BLK, tmo, crc)) push_fail(ER_WRITE);
                    else phase = PH_WR_DATA;
                end
                PH_WR_POLL: begin
                    st = resp[12:9];
                    if (!resp_good(CMD_STATUS, tmo, crc)) begin
                        if (attempts != 0) attempts--;
                        if (attempts == 0) push_fail(ER_WRITE);
                        else push_cmd(CMD_STATUS, {rca, 16'd0}, DIR_NONE, 1000);
                    end else if (st != 4'd6 && st != 4'd7) push_done(1);
                    else push_cmd(CMD_STATUS, {rca, 16'd0}, DIR_NONE, 1000);
                end
                PH_DI_CD: begin
                    r = check_step(tmo, crc, resp);
                    if (r != 2) begin
                        if (r == 1) flags[FB_CDOFF] = 0;
                        shutdown_next(PH_DI_SEL);
                    end
                end
                PH_DI_SEL: begin
                    flags[FB_XFER] = 0;
                    shutdown_next(PH_DI_IDLE);
                end
                PH_DI_IDLE: begin
                    power = 0;
                    rca = '0;
                    push_done(1);
                end
                default: ;
            endcase
        endfunction

        // returns 1 when the beat leads to a result
        function bit note_event(t_in_item it);
            int q_before;
            logic [31:0] addr;
            q_before = pending_q.size();
            case (it.op)
                OP_START: if (phase == PH_IDLE) begin
                    power = 1;
                    flags = '0;
                    last_err = ER_NONE;
                    rca = '0;
                    version = '0;
                    divider = rate_divider(init_hz);
                    phase = PH_RST0;
                    push_cmd(CMD_GO_IDLE, 0, DIR_NONE, 17'd2000);
                end
                OP_CMD: command_done(it.resp_timeout, it.resp_crc_fail, it.resp_word,
                                     it.csd_word);
                OP_READ, OP_WRITE: if (phase == PH_IDLE) begin
                    if (!flags[FB_INIT]) push_done(0);
                    else begin
                        addr = flags[FB_HC] ? it.sector : (it.sector << SECTOR_SHIFT);
                        if (it.op == OP_READ) begin
                            phase = PH_RD_CMD;
                            push_cmd(CMD_READ_BLK, addr, DIR_READ, 0);
                        end else begin
                            phase = PH_WR_CMD;
                            push_cmd(CMD_WRITE_BLK, addr, DIR_WRITE, 0);
                        end
                    end
                end
                OP_DATA: begin
                    if (phase == PH_RD_DATA) begin
                        if (it.data_complete) push_done(1);
                        else push_fail(ER_READ);
                    end else if (phase == PH_WR_DATA) begin
                        if (!it.data_complete) push_fail(ER_WRITE);
                        else begin
                            phase = PH_WR_POLL;
                            attempts = 100;
                            push_cmd(CMD_STATUS, {rca, 16'd0}, DIR_NONE, 1000);
                        end
                    end
                end
                OP_DEINIT: if (phase == PH_IDLE) begin
                    if (flags[FB_DEINIT]) push_done(1);
                    else begin
                        flags[FB_DEINIT] = 1;
                        shutdown_next(PH_DI_CD);
                    end
                end
                default: ;
            endcase
            n_events++;
            return pending_q.size() != q_before;
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_q.size() == 0) begin
                $error("result beat with nothing expected: %p", got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (want.done_res) n_dones++;
            else n_cmds++;
            cmp_field("issue_cmd", want.issue_cmd, got.issue_cmd);
            cmp_field("cmd_index", want.cmd_index, got.cmd_index);
            cmp_field("cmd_arg", want.cmd_arg, got.cmd_arg);
            cmp_field("resp_kind", want.resp_kind, got.resp_kind);
            cmp_field("data_dir", want.data_dir, got.data_dir);
            cmp_field("wait_us", want.wait_us, got.wait_us);
            cmp_field("clock_div", want.clock_div, got.clock_div);
            cmp_field("power_on", want.power_on, got.power_on);
            cmp_field("done_res", want.done_res, got.done_res);
            cmp_field("success", want.success, got.success);
            cmp_field("error_code", want.error_code, got.error_code);
            cmp_field("status_flags", want.status_flags, got.status_flags);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [26:0] i_cfg_data;

    sdcs_stream_if #(.T(t_in_item))  ev_if ();
    sdcs_stream_if #(.T(t_out_item)) res_if ();

    sd_card_command_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .in_ch       (ev_if),
        .out_ch      (res_if)
    );

    sdcs_scoreboard sb;
    bit no_idle;
    bit hold_req;
    int n_settings;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // mostly well-formed events for the current phase, some noise
    function automatic t_in_item pick_event(bit good);
        t_in_item it;
        int r;
        it.op = OP_CMD;
        it.resp_timeout = 0;
        it.resp_crc_fail = 0;
        it.resp_word = $urandom;
        it.csd_word = $urandom;
        it.sector = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 1023);
        it.data_complete = 1;
        r = $urandom_range(0, 99);
        if (!good) begin
            if ($urandom_range(0, 99) < 8) begin
                it.op = 3'($urandom_range(0, 7));
                it.resp_timeout = 1'($urandom_range(0, 1));
                it.resp_crc_fail = 1'($urandom_range(0, 1));
                it.data_complete = 1'($urandom_range(0, 1));
                return it;
            end
            it.resp_timeout = ($urandom_range(0, 99) < 6);
            it.resp_crc_fail = ($urandom_range(0, 99) < 6);
            it.data_complete = ($urandom_range(0, 99) < 90);
        end
        case (sb.phase)
            PH_IDLE: begin
                if (!sb.flags[FB_INIT])
                    it.op = (r < 80) ? OP_START : (r < 88) ? OP_READ :
                            (r < 94) ? OP_WRITE : OP_DEINIT;
                else
                    it.op = (r < 40) ? OP_READ : (r < 80) ? OP_WRITE :
                            (r < 90) ? OP_DEINIT : OP_START;
            end
            PH_RD_DATA, PH_WR_DATA: it.op = OP_DATA;
            PH_IFC: if (good || r < 85) begin
                it.resp_word[22] = 0;
                it.resp_word[11:0] = IF_PATTERN;
            end
            PH_OPC: if (good || r < 80) begin
                it.resp_word[31] = 1;
                it.resp_word[20] = 1;
            end
            PH_RCA: begin
                if (!good && r < 10) it.resp_word[31:16] = '0;
                else if (it.resp_word[31:16] == 0) it.resp_word[16] = 1;
            end
            PH_CSD: if (good || r < 85) it.csd_word[13:12] = '0;
            PH_BLEN: if (good || r < 85) it.resp_word[29] = 0;
            PH_WR_POLL: begin
                // card still programming
                if (!good && r < 30) it.resp_word[12:9] = 4'd6 + 4'($urandom_range(0, 1));
                else it.resp_word[12:9] = 4'd4;
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_event(t_in_item it, output bit has_res);
        int g;
        ev_if.valid <= 1;
        ev_if.payload <= it;
        @(posedge i_clk);
        while (!ev_if.ready) @(posedge i_clk);
        has_res = sb.note_event(it);
        g = gap_len();
        if (g > 0) begin
            ev_if.valid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_op(logic [2:0] op);
        t_in_item it;
        bit hr;
        it = pick_event(1);
        it.op = op;
        send_event(it, hr);
    endtask

    task automatic run_until_idle();
        bit hr;
        do send_event(pick_event(1), hr); while (sb.phase != PH_IDLE);
    endtask

    task automatic drain();
        ev_if.valid <= 0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        // covers the divider pass of an event that gives no beat
        repeat (40) @(posedge i_clk);
    endtask

    task automatic program_rates(logic [26:0] adapter, logic [26:0] init_r,
                                 logic [26:0] xfer);
        logic [26:0] vals[3];
        vals = '{adapter, init_r, xfer};
        for (int i = 0; i < 3; i++) begin
            i_cfg_we <= 1;
            i_cfg_index <= 3'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.set_reg(3'(i), vals[i]);
        end
        i_cfg_we <= 0;
        n_settings++;
    endtask

    // ready side: random stalls plus one long hold when asked
    initial begin
        int stall_left;
        stall_left = 0;
        res_if.ready = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                res_if.ready <= 0;
                stall_left--;
            end else if (hold_req) begin
                hold_req = 0;
                stall_left = 400;
                res_if.ready <= 0;
            end else if (!no_idle && $urandom_range(0, 99) < 25) begin
                stall_left = gap_len();
                res_if.ready <= 0;
            end else res_if.ready <= 1;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && res_if.valid && res_if.ready) sb.check_result(res_if.payload);

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_in_item it;
        bit hr;
        int produced;
        sb = new();
        sb.reset_state();
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_index = CFG_ADAPTER;
        i_cfg_data = '0;
        ev_if.valid = 0;
        ev_if.payload = '0;
        no_idle = 0;
        hold_req = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: undefined ops, access before init, shutdown from cold, then start, read, write, shutdown
        send_op(OP_BAD_A);
        send_op(OP_BAD_B);
        send_op(OP_READ);
        send_op(OP_WRITE);
        send_op(OP_DEINIT);
        run_until_idle();
        send_op(OP_DEINIT);
        send_op(OP_START);
        run_until_idle();
        send_op(OP_READ);
        run_until_idle();
        send_op(OP_WRITE);
        run_until_idle();
        send_op(OP_DEINIT);
        run_until_idle();
        drain();

        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0: program_rates(27'd50000000, 27'd400000, 27'd4000000);
                1: program_rates(27'd1000000, 27'd100000, 27'd400000);
                2: program_rates(27'd100000000, 27'd400000, 27'd50000000);
                3: program_rates('1, '0, '0);
                4: program_rates(27'($urandom_range(1000000, 100000000)),
                                 27'($urandom_range(100000, 400000)),
                                 27'($urandom_range(400000, 50000000)));
                default: program_rates(27'($urandom), 27'($urandom), 27'($urandom));
            endcase
            no_idle = (seg == 1);
            produced = 0;
            while (produced < 125) begin
                if (seg == 2 && produced == 60) hold_req = 1;
                if (seg == 4 && produced == 75) drain();
                send_event(pick_event(0), hr);
                if (hr) produced++;
            end
            // return to idle so the next setting lands between sequences
            while (sb.phase != PH_IDLE) send_event(pick_event(0), hr);
            drain();
        end

        $display("covered %0d event beats, %0d command and %0d completion results",
                 sb.n_events, sb.n_cmds, sb.n_dones);
        $display("across %0d rate settings including zero and full-scale rates",
                 n_settings);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
